// ===== rtl/mrpd_pkg.sv =====
// mrpd_pkg: constants, types and helper functions of the med rice plane decoder
package mrpd_pkg;

  localparam int MAX_WIDTH = 4096;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int EW        = COL_W + 1;

  localparam int WIDTH_W  = 13;
  localparam int HEIGHT_W = 16;
  localparam int OFFSET_W = 8;
  localparam int PIX_W    = 8;
  localparam int CNT_W    = 5;
  localparam int K_W      = 4;
  localparam int REM_W    = 9;
  localparam int PH_W     = 2;
  localparam int WORD_W   = 32;
  localparam int CODE_W   = WORD_W + REM_W;
  localparam int DELTA_W  = WORD_W + 2;
  localparam int SSUM_W   = WORD_W + 3;

  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 32;
  localparam int IDX_W    = ADDR_W - 2;

  localparam int K_MAX         = 9;
  localparam int RUN_K         = 2;
  localparam int SUM_RESET     = 8;
  localparam int CNT_RESET     = 1;
  localparam int CNT_HALVE     = 16;
  localparam int PRED_START    = 128;
  localparam int SCORE_PENALTY = 3;
  localparam int PEND_LIMIT    = 2;

  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(1);
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(1);

  typedef logic [PH_W-1:0]   phase_t;
  typedef logic [COL_W-1:0]  col_t;
  typedef logic [PIX_W-1:0]  pix_t;
  typedef logic [IDX_W-1:0]  reg_idx_t;

  localparam phase_t PH_RES_PREFIX = 2'd0;
  localparam phase_t PH_RES_SUFFIX = 2'd1;
  localparam phase_t PH_RUN_PREFIX = 2'd2;
  localparam phase_t PH_RUN_SUFFIX = 2'd3;

  localparam reg_idx_t CFG_WIDTH  = 2'd0;
  localparam reg_idx_t CFG_HEIGHT = 2'd1;
  localparam reg_idx_t CFG_OFFSET = 2'd2;

  function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t c);
    logic signed [PIX_W+1:0] sa;
    logic signed [PIX_W+1:0] sb;
    logic signed [PIX_W+1:0] g;
    logic signed [PIX_W+1:0] lo;
    logic signed [PIX_W+1:0] hi;
    logic signed [PIX_W+1:0] m;
    sa = signed'({2'b00, a});
    sb = signed'({2'b00, b});
    g  = sa + sb - signed'({2'b00, c});
    lo = (sa < sb) ? sa : sb;
    hi = (sa < sb) ? sb : sa;
    m  = (hi < g) ? hi : g;
    return (lo > m) ? lo[PIX_W-1:0] : m[PIX_W-1:0];
  endfunction

  function automatic logic [K_W-1:0] param_k(input logic [WORD_W-1:0] sum,
                                             input logic [CNT_W-1:0] cnt);
    logic [K_W-1:0] k;
    k = '0;
    for (int j = 0; j < K_MAX; j++) begin
      if (sum > (WORD_W'(cnt) << j)) k = K_W'(j + 1);
    end
    return k;
  endfunction

  function automatic logic [EW-1:0] eff_width(input logic [WIDTH_W-1:0] w);
    logic [WORD_W-1:0] wz;
    wz = WORD_W'(w);
    if (wz == '0) return EW'(1);
    if (wz > WORD_W'(MAX_WIDTH)) return EW'(MAX_WIDTH);
    return EW'(wz);
  endfunction

endpackage

// ===== rtl/med_rice_plane_decoder.sv =====
// med_rice_plane_decoder: adaptive rice decoder with median prediction for one 8-bit plane
//
// input channel: one beat per code bit (in_stream_bit, in_bit_valid), valid/ready.
// each input beat gives exactly one output beat (bit taken, pixel, plane done).
// a beat lands in the input register, is decoded in one pass as it leaves it and
// sits in the output register until taken, so a result beat passes the input and
// output registers after its input is accepted. one beat per cycle sustained while
// out_ready holds; the pace is set by the single decode pass, with the line store's
// registered read addressed by the next column so the above pixel is ready for the
// following beat.
// configuration: apb-style port, width 0x0, height 0x4, lossy offset 0x8; the user keeps
// them written only while the decoder holds no beat, which the block does not enforce.
// reset: width 1, height 1, offset 0, decoder at plane start. the line store is not
// cleared; no pixel of row zero depends on it.
// receiver stall: the output register holds its beat, the input register fills,
// then in_ready drops until out_ready returns.
module med_rice_plane_decoder
  import mrpd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_stream_bit,
  input  logic              in_bit_valid,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_bit_taken,
  output logic              out_pixel_valid,
  output logic [PIX_W-1:0]  out_pixel_value,
  output logic              out_plane_done,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [DATA_W-1:0] cfg_pwdata,
  output logic [DATA_W-1:0] cfg_prdata,
  output logic              cfg_pready
);

  // configuration
  logic [WIDTH_W-1:0]  width_r;
  logic [HEIGHT_W-1:0] height_r;
  logic [OFFSET_W-1:0] offset_r;
  logic                cfg_wr;
  reg_idx_t            cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_idx    = cfg_paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
      offset_r <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        CFG_WIDTH:  width_r  <= cfg_pwdata[WIDTH_W-1:0];
        CFG_HEIGHT: height_r <= cfg_pwdata[HEIGHT_W-1:0];
        CFG_OFFSET: offset_r <= cfg_pwdata[OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      CFG_WIDTH:  cfg_prdata = DATA_W'(width_r);
      CFG_HEIGHT: cfg_prdata = DATA_W'(height_r);
      CFG_OFFSET: cfg_prdata = DATA_W'(offset_r);
      default:    cfg_prdata = '0;
    endcase
  end

  // input register and beat flow
  logic in_v_r;
  logic bit_r;
  logic bv_r;
  logic out_v_r;
  logic s_fire;

  assign s_fire   = in_v_r & (~out_v_r | out_ready);
  assign in_ready = ~in_v_r | s_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      bit_r <= in_stream_bit;
      bv_r  <= in_bit_valid;
    end
  end

  // decoder state
  phase_t              phase_r,  phase_nxt;
  logic [WORD_W-1:0]   q_r,      q_nxt;
  logic [REM_W-1:0]    rem_r,    rem_nxt;
  logic [K_W-1:0]      sl_r,     sl_nxt;
  logic [K_W-1:0]      k_r,      k_nxt;
  logic [WORD_W-1:0]   zrl_r,    zrl_nxt;
  logic [WORD_W-1:0]   pend_r,   pend_nxt;
  logic [WORD_W-1:0]   score_r,  score_nxt;
  logic [WORD_W-1:0]   sum_r,    sum_nxt;
  logic [CNT_W-1:0]    cnt_r,    cnt_nxt;
  pix_t                left_r,   left_nxt;
  pix_t                ul_r,     ul_nxt;
  col_t                col_r,    col_nxt;
  logic [HEIGHT_W-1:0] row_r,    row_nxt;

  // line store and bypass of a same-address write
  pix_t ram_q;
  pix_t above;
  logic byp_r;
  pix_t byp_data_r;
  logic emit;
  pix_t p;

  mrpd_ram #(
    .DATA_W (PIX_W),
    .DEPTH  (MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (emit),
    .waddr (col_r),
    .wdata (p),
    .raddr (col_nxt),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_r <= 1'b0;
    end else begin
      byp_r <= emit & (col_r == col_nxt);
    end
    byp_data_r <= p;
  end

  assign above = byp_r ? byp_data_r : ram_q;

  // code assembly
  logic                zr_step;
  logic [K_W-1:0]      k_calc;
  logic [K_W-1:0]      k_new;
  logic [K_W-1:0]      k_use;
  logic [REM_W-1:0]    rem_shift;
  logic [REM_W-1:0]    rem_use;
  logic [K_W-1:0]      sl_dec;
  logic [CODE_W-1:0]   code;
  logic                code_zero;
  logic [CODE_W:0]     code_p1;
  logic [WORD_W-1:0]   q_inc;
  logic [WORD_W-1:0]   pend_inc;

  assign zr_step   = (phase_r == PH_RES_PREFIX) && (zrl_r != '0);
  assign k_calc    = param_k(sum_r, cnt_r);
  assign k_new     = phase_r[1] ? K_W'(RUN_K) : k_calc;
  assign rem_shift = {rem_r[REM_W-2:0], bit_r};
  assign k_use     = phase_r[0] ? k_r : k_new;
  assign rem_use   = phase_r[0] ? rem_shift : '0;
  assign sl_dec    = sl_r - K_W'(1);
  assign code      = (CODE_W'(q_r) << k_use) | CODE_W'(rem_use);
  assign code_zero = (code == '0);
  assign code_p1   = {1'b0, code} + (CODE_W+1)'(1);
  assign q_inc     = (q_r == '1) ? q_r : q_r + WORD_W'(1);
  assign pend_inc  = (pend_r == '1) ? pend_r : pend_r + WORD_W'(1);

  // context adaptation
  logic [CODE_W-1:0]   adapt_mag;
  logic [CODE_W:0]     sum_w;
  logic [WORD_W-1:0]   sum_sat;
  logic [CNT_W-1:0]    cnt_inc;
  logic [WORD_W-1:0]   sum_ad;
  logic [CNT_W-1:0]    cnt_ad;

  assign adapt_mag = zr_step ? '0 : code_p1[CODE_W:1];
  assign sum_w     = (CODE_W+1)'(sum_r) + (CODE_W+1)'(adapt_mag);
  assign sum_sat   = (|sum_w[CODE_W:WORD_W]) ? '1 : sum_w[WORD_W-1:0];
  assign cnt_inc   = cnt_r + CNT_W'(1);
  assign sum_ad    = (cnt_inc == CNT_W'(CNT_HALVE)) ? (sum_sat >> 1) : sum_sat;
  assign cnt_ad    = (cnt_inc == CNT_W'(CNT_HALVE)) ? (cnt_inc >> 1) : cnt_inc;

  // run score, saturating to the signed word range
  logic [WORD_W-1:0]   run;
  logic [DELTA_W-1:0]  neg_pen;
  logic [DELTA_W-1:0]  run_d;
  logic [DELTA_W-1:0]  pend_d;
  logic [DELTA_W-1:0]  delta;
  logic [SSUM_W-1:0]   score_w;
  logic [WORD_W-1:0]   score_ad;

  assign run     = (|code[CODE_W-1:WORD_W]) ? '1 : code[WORD_W-1:0];
  assign neg_pen = DELTA_W'(0) - DELTA_W'(SCORE_PENALTY);
  assign run_d   = (run > WORD_W'(1)) ? (DELTA_W'(run) + DELTA_W'(1)) : neg_pen;
  assign pend_d  = (pend_r > WORD_W'(PEND_LIMIT)) ? DELTA_W'(pend_r) : neg_pen;
  assign delta   = phase_r[1] ? run_d : pend_d;
  assign score_w = {{(SSUM_W-WORD_W){score_r[WORD_W-1]}}, score_r}
                 + {{(SSUM_W-DELTA_W){delta[DELTA_W-1]}}, delta};

  always_comb begin
    if (!score_w[SSUM_W-1] && (|score_w[SSUM_W-2:WORD_W-1])) begin
      score_ad = {1'b0, {(WORD_W-1){1'b1}}};
    end else if (score_w[SSUM_W-1] && !(&score_w[SSUM_W-2:WORD_W-1])) begin
      score_ad = {1'b1, {(WORD_W-1){1'b0}}};
    end else begin
      score_ad = score_w[WORD_W-1:0];
    end
  end

  // residual and median prediction
  pix_t              mag8;
  pix_t              res8;
  pix_t              pred;
  logic [EW-1:0]     w_eff;
  logic [HEIGHT_W-1:0] h_eff;
  logic [EW-1:0]     col_inc;
  col_t              col_em;
  logic [HEIGHT_W-1:0] row_em;

  assign mag8  = code[PIX_W:1] + offset_r;
  assign res8  = (zr_step || code_zero) ? '0 : (code[0] ? ~mag8 : mag8);
  assign w_eff = eff_width(width_r);
  assign h_eff = (height_r == '0) ? HEIGHT_W'(1) : height_r;

  always_comb begin
    if (row_r == '0) begin
      pred = (col_r == '0) ? PIX_W'(PRED_START) : left_r;
    end else if (col_r == '0) begin
      pred = above;
    end else begin
      pred = med3(above, left_r, ul_r);
    end
  end

  assign p       = pred + res8;
  assign col_inc = {1'b0, col_r} + EW'(1);

  always_comb begin
    if (col_inc >= w_eff) begin
      col_em = '0;
      row_em = row_r + HEIGHT_W'(1);
    end else begin
      col_em = col_inc[COL_W-1:0];
      row_em = row_r;
    end
  end

  // one decode step
  logic taken;
  logic pv;
  logic finish;
  logic done_chk;
  logic adapt_en;
  logic score_en;
  logic done;
  logic [HEIGHT_W-1:0] row_chk;

  always_comb begin
    phase_nxt = phase_r;
    q_nxt     = q_r;
    rem_nxt   = rem_r;
    sl_nxt    = sl_r;
    k_nxt     = k_r;
    zrl_nxt   = zrl_r;
    pend_nxt  = pend_r;
    score_nxt = score_r;
    sum_nxt   = sum_r;
    cnt_nxt   = cnt_r;
    left_nxt  = left_r;
    ul_nxt    = ul_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    taken     = 1'b0;
    pv        = 1'b0;
    emit      = 1'b0;
    finish    = 1'b0;
    done_chk  = 1'b0;
    adapt_en  = 1'b0;
    score_en  = 1'b0;
    done      = 1'b0;
    row_chk   = row_r;

    if (s_fire) begin
      if (zr_step) begin
        zrl_nxt  = zrl_r - WORD_W'(1);
        adapt_en = 1'b1;
        pv       = 1'b1;
        emit     = 1'b1;
        done_chk = 1'b1;
      end else if (bv_r) begin
        taken = 1'b1;
        if (!phase_r[0]) begin
          if (!bit_r) begin
            q_nxt = q_inc;
          end else begin
            k_nxt   = k_new;
            rem_nxt = '0;
            if (k_new == '0) begin
              finish = 1'b1;
            end else begin
              sl_nxt    = k_new;
              phase_nxt = phase_r | PH_RES_SUFFIX;
            end
          end
        end else begin
          rem_nxt = rem_shift;
          sl_nxt  = sl_dec;
          if (sl_dec == '0) finish = 1'b1;
        end

        if (finish) begin
          q_nxt     = '0;
          rem_nxt   = '0;
          phase_nxt = PH_RES_PREFIX;
          if (phase_r[1]) begin
            score_en = 1'b1;
            zrl_nxt  = run;
            done_chk = 1'b1;
          end else begin
            adapt_en = 1'b1;
            pv       = 1'b1;
            emit     = 1'b1;
            if (code_zero) begin
              if (!score_r[WORD_W-1]) begin
                phase_nxt = PH_RUN_PREFIX;
              end else begin
                pend_nxt = pend_inc;
                done_chk = 1'b1;
              end
            end else begin
              if (pend_r != '0) begin
                score_en = 1'b1;
                pend_nxt = '0;
              end
              done_chk = 1'b1;
            end
          end
        end
      end
    end

    if (adapt_en) begin
      sum_nxt = sum_ad;
      cnt_nxt = cnt_ad;
    end
    if (score_en) begin
      score_nxt = score_ad;
    end
    if (emit) begin
      left_nxt = p;
      ul_nxt   = above;
      col_nxt  = col_em;
      row_nxt  = row_em;
      row_chk  = row_em;
    end

    done = done_chk && (row_chk >= h_eff);

    // plane finished: back to plane start
    if (done) begin
      phase_nxt = PH_RES_PREFIX;
      q_nxt     = '0;
      rem_nxt   = '0;
      sl_nxt    = '0;
      k_nxt     = '0;
      zrl_nxt   = '0;
      pend_nxt  = '0;
      score_nxt = '0;
      sum_nxt   = WORD_W'(SUM_RESET);
      cnt_nxt   = CNT_W'(CNT_RESET);
      left_nxt  = '0;
      ul_nxt    = '0;
      col_nxt   = '0;
      row_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_RES_PREFIX;
      q_r     <= '0;
      rem_r   <= '0;
      sl_r    <= '0;
      k_r     <= '0;
      zrl_r   <= '0;
      pend_r  <= '0;
      score_r <= '0;
      sum_r   <= WORD_W'(SUM_RESET);
      cnt_r   <= CNT_W'(CNT_RESET);
      left_r  <= '0;
      ul_r    <= '0;
      col_r   <= '0;
      row_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      q_r     <= q_nxt;
      rem_r   <= rem_nxt;
      sl_r    <= sl_nxt;
      k_r     <= k_nxt;
      zrl_r   <= zrl_nxt;
      pend_r  <= pend_nxt;
      score_r <= score_nxt;
      sum_r   <= sum_nxt;
      cnt_r   <= cnt_nxt;
      left_r  <= left_nxt;
      ul_r    <= ul_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
    end
  end

  // output register
  logic taken_r;
  logic pv_r;
  pix_t pix_r;
  logic done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s_fire) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      taken_r <= taken;
      pv_r    <= pv;
      pix_r   <= pv ? p : '0;
      done_r  <= done;
    end
  end

  assign out_valid       = out_v_r;
  assign out_bit_taken   = taken_r;
  assign out_pixel_valid = pv_r;
  assign out_pixel_value = pix_r;
  assign out_plane_done  = done_r;

  // checks
  a_done_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (s_fire && done) |=> (col_r == '0 && row_r == '0 && phase_r == PH_RES_PREFIX))
    else $error("plane end did not return to plane start");

  a_run_in_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    (zrl_r != '0) |-> (phase_r == PH_RES_PREFIX))
    else $error("zero run pending outside residual prefix");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != '0) && (cnt_r < CNT_W'(CNT_HALVE)))
    else $error("sample count out of range");

  a_suffix_left: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r[0] |-> (sl_r != '0))
    else $error("suffix phase with no suffix bits left");

  a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_v_r |-> in_ready)
    else $error("input stalled with empty output register");

endmodule

// ===== rtl/mrpd_ram.sv =====
// mrpd_ram: generic single write port ram with registered read
module mrpd_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
